>>> hdl/grs_pkg.sv
package grs_pkg;

    // Field widths fixed by the stream format
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned GS_W          = 5;

    // Defaults
    localparam int unsigned MAX_GROUP_DEF = 16;
    localparam logic [GS_W-1:0] GS_RESET  = 5'd2;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_FILL  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

endpackage

>>> hdl/grs_ram.sv
module grs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/group_reverse_stream_top.sv
// Group reverse stream: values arriving on the slave stream are collected in a
// buffer RAM; once group_size values are held (group_size 0 acts as 1, values
// above MAX_GROUP act as MAX_GROUP) the group is sent out newest first, and if
// tlast arrives on an incomplete group the held values are sent out oldest
// first. m_axis_tlast marks the final output of the run. Each input is accepted
// while the block is filling; a completed group is then read back through the
// single RAM read port, during which s_axis_tready is low. A two-entry output
// queue keeps the read stream running at one value per cycle while the
// downstream accepts every cycle, stalls reads under backpressure, and lets the
// next group start filling while the last results wait. group_size is written
// through i_cfg_we / i_cfg_wdata and should only change while the block is idle.
module group_reverse_stream_top #(
    parameter int unsigned MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [grs_pkg::GS_W-1:0]            i_cfg_wdata,   // group_size
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [grs_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] item_value
    input  logic                                s_axis_tlast,  // end_of_sequence
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [grs_pkg::DATA_W-1:0]   m_axis_tdata,  // [31:0] out_value
    output logic                                m_axis_tlast   // out_last
);

    import grs_pkg::*;

    localparam int unsigned AW   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int unsigned CW   = $clog2(MAX_GROUP + 1);
    localparam int unsigned CMPW = (CW > GS_W) ? CW : GS_W;

    // registers
    t_state             r_state,       n_state;
    logic [GS_W-1:0]    r_group_size,  n_group_size;
    logic [CW-1:0]      r_fill,        n_fill;
    logic [AW-1:0]      r_rd_addr,     n_rd_addr;
    logic               r_down,        n_down;
    logic [CW-1:0]      r_left,        n_left;
    logic               r_eos,         n_eos;
    logic               r_inflight,    n_inflight;
    logic               r_infl_last,   n_infl_last;
    logic [DATA_W-1:0]  r_q_val  [2];
    logic               r_q_last [2];
    logic               r_q_head,      n_q_head;
    logic [1:0]         r_q_count,     n_q_count;

    logic               in_acc;
    logic               out_pop;
    logic               issue;
    logic [1:0]         occ;
    logic [CMPW-1:0]    gs_ext;
    logic [CMPW-1:0]    k_eff;
    logic [CMPW-1:0]    n_items;
    logic               q_tail;
    logic [DATA_W-1:0]  ram_rdata;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_pop = m_axis_tvalid && m_axis_tready;

    // effective group size: clamp to 1..MAX_GROUP
    assign gs_ext  = CMPW'(r_group_size);
    assign k_eff   = (gs_ext == '0) ? CMPW'(1) :
                     (gs_ext > CMPW'(MAX_GROUP)) ? CMPW'(MAX_GROUP) : gs_ext;
    assign n_items = CMPW'(r_fill) + CMPW'(1);

    // read issue: keep queued plus in-flight results at two or fewer
    assign occ   = r_q_count + {1'b0, r_inflight};
    assign issue = (r_state == S_DRAIN) && ((occ < 2'd2) || out_pop);

    assign q_tail = r_q_head ^ r_q_count[0];

    assign s_axis_tready = (r_state == S_FILL);
    assign m_axis_tvalid = (r_q_count != 2'd0);
    assign m_axis_tdata  = r_q_val[r_q_head];
    assign m_axis_tlast  = r_q_last[r_q_head];

    // group buffer
    grs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_GROUP)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (issue),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    // fill / drain control
    always_comb begin
        n_state      = r_state;
        n_group_size = i_cfg_we ? i_cfg_wdata : r_group_size;
        n_fill       = r_fill;
        n_rd_addr    = r_rd_addr;
        n_down       = r_down;
        n_left       = r_left;
        n_eos        = r_eos;
        n_inflight   = issue;
        n_infl_last  = r_eos && (r_left == CW'(1));

        case (r_state)
            S_FILL: begin
                if (in_acc) begin
                    if (n_items >= k_eff) begin
                        // full group: newest first
                        n_state   = S_DRAIN;
                        n_rd_addr = r_fill[AW-1:0];
                        n_down    = 1'b1;
                        n_left    = r_fill + CW'(1);
                        n_eos     = s_axis_tlast;
                        n_fill    = '0;
                    end else if (s_axis_tlast) begin
                        // partial group at end of run: arrival order
                        n_state   = S_DRAIN;
                        n_rd_addr = '0;
                        n_down    = 1'b0;
                        n_left    = r_fill + CW'(1);
                        n_eos     = 1'b1;
                        n_fill    = '0;
                    end else begin
                        n_fill    = r_fill + CW'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (issue) begin
                    n_rd_addr = r_down ? (r_rd_addr - AW'(1)) : (r_rd_addr + AW'(1));
                    n_left    = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_state = S_FILL;
                    end
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    // output queue pointers
    always_comb begin
        n_q_head  = out_pop ? ~r_q_head : r_q_head;
        n_q_count = r_q_count + {1'b0, r_inflight} - {1'b0, out_pop};
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_group_size <= GS_RESET;
            r_fill       <= '0;
            r_inflight   <= 1'b0;
            r_q_head     <= 1'b0;
            r_q_count    <= 2'd0;
        end else begin
            r_state      <= n_state;
            r_group_size <= n_group_size;
            r_fill       <= n_fill;
            r_inflight   <= n_inflight;
            r_q_head     <= n_q_head;
            r_q_count    <= n_q_count;
        end
    end

    // drain pointers and queue payload
    always_ff @(posedge i_clk) begin
        r_rd_addr   <= n_rd_addr;
        r_down      <= n_down;
        r_left      <= n_left;
        r_eos       <= n_eos;
        r_infl_last <= n_infl_last;
        if (r_inflight) begin
            r_q_val[q_tail]  <= ram_rdata;
            r_q_last[q_tail] <= r_infl_last;
        end
    end

endmodule
